// ----- design/rmh_pkg.sv -----
`default_nettype none

package rmh_pkg;

  // storage per half and derived widths
  localparam int HEAP_DEPTH = 1024;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int SIZE_W     = $clog2(HEAP_DEPTH + 1);
  localparam int CAPACITY   = 2 * HEAP_DEPTH - 1;

  // fixed field widths
  localparam int SAMPLE_W   = 32;
  localparam int MEDIAN_W   = 33;
  localparam int COUNT_W    = 11;
  localparam int OUT_DATA_W = ((MEDIAN_W + COUNT_W + 7) / 8) * 8;
  localparam int TOTAL_W    = SIZE_W + 1;

  // operation applied to a whole row of cells at once
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_POP  = 2'd2
  } row_op_t;

  typedef struct packed {
    row_op_t               op;
    logic [SAMPLE_W-1:0]   value;
  } row_cmd_t;

endpackage

`default_nettype wire

// ----- design/rmh_cell.sv -----
`default_nettype none

module rmh_cell (
  input  wire logic                         clk,
  input  wire logic                         is_max,
  input  wire logic [rmh_pkg::IDX_W-1:0]    idx,
  input  wire logic [rmh_pkg::SIZE_W-1:0]   size,
  input  wire rmh_pkg::row_cmd_t            cmd,
  input  wire logic                         left_keep,
  input  wire logic [rmh_pkg::SAMPLE_W-1:0] left_val,
  input  wire logic [rmh_pkg::SAMPLE_W-1:0] right_val,
  output logic                              keep,
  output logic [rmh_pkg::SAMPLE_W-1:0]      val
);
  import rmh_pkg::*;

  logic                occupied;
  logic                ranks_ok;
  logic [SAMPLE_W-1:0] val_next;

  // an occupied entry that ranks at or above the new word stays in place
  assign occupied = ({1'b0, idx} < size);
  assign ranks_ok = is_max ? ($signed(val) >= $signed(cmd.value))
                           : ($signed(val) <= $signed(cmd.value));
  assign keep     = occupied && ranks_ok;

  // insert: first non-kept cell takes the word, later ones shift right; pop: entries shift left toward cell zero
  always_comb begin
    unique case (cmd.op)
      CMD_PUSH: begin
        if (keep) begin
          val_next = val;
        end else if (left_keep) begin
          val_next = cmd.value;
        end else begin
          val_next = left_val;
        end
      end
      CMD_POP:  val_next = right_val;
      default:  val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

`default_nettype wire

// ----- design/rmh_row.sv -----
`default_nettype none

module rmh_row (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         is_max,
  input  wire rmh_pkg::row_cmd_t            cmd,
  output logic [rmh_pkg::SIZE_W-1:0]        size,
  output logic [rmh_pkg::SAMPLE_W-1:0]      top
);
  import rmh_pkg::*;

  logic                keep [HEAP_DEPTH];
  logic [SAMPLE_W-1:0] val  [HEAP_DEPTH];

  // sorted row of cells, best-ranked entry in cell zero
  for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
    logic                c_left_keep;
    logic [SAMPLE_W-1:0] c_left_val;
    logic [SAMPLE_W-1:0] c_right_val;

    if (i == 0) begin : g_first
      assign c_left_keep = 1'b1;
      assign c_left_val  = cmd.value;
    end else begin : g_inner
      assign c_left_keep = keep[i-1];
      assign c_left_val  = val[i-1];
    end

    if (i == HEAP_DEPTH - 1) begin : g_last
      assign c_right_val = val[i];
    end else begin : g_body
      assign c_right_val = val[i+1];
    end

    rmh_cell u_cell (
      .clk       (clk),
      .is_max    (is_max),
      .idx       (IDX_W'(i)),
      .size      (size),
      .cmd       (cmd),
      .left_keep (c_left_keep),
      .left_val  (c_left_val),
      .right_val (c_right_val),
      .keep      (keep[i]),
      .val       (val[i])
    );
  end

  assign top = val[0];

  // fill count of the row
  always_ff @(posedge clk) begin
    if (rst) begin
      size <= '0;
    end else begin
      unique case (cmd.op)
        CMD_PUSH: size <= size + SIZE_W'(1);
        CMD_POP:  size <= size - SIZE_W'(1);
        default:  size <= size;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/running_median_two_heaps.sv -----
`default_nettype none

// Running median of a stream of signed 32-bit samples.
// Input channel s_*: one sample per word in s_tdata[31:0].
// Output channel m_*: one result word per sample; m_tdata holds twice the
// median [32:0] and the held sample count [43:33]; m_tuser is set when the
// sample was dropped because all 2*HEAP_DEPTH-1 places are taken.
// The two halves are two rows of cells kept in sorted order, best entry in
// the first cell, so each top is always at hand. A sample is inserted into
// one row in the cycle it is accepted; the next cycle moves one entry from
// one row to the other where the halves are out of balance; after that the
// output register is loaded once it is free. A dropped sample is not inserted
// and skips the rebalance step. A new sample is taken only once the result of
// the previous one is loaded, after the insert, rebalance and result steps of
// the cell rows.
// Reset empties both halves and the output register; the cell contents are
// not cleared and are never read before written.
// When the receiver stalls the result waits in the output register while
// the next sample is still taken and processed; that sample then waits for
// the register to free up, and no further sample is accepted meanwhile.
module running_median_two_heaps (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [rmh_pkg::SAMPLE_W-1:0]    s_tdata,  // [31:0] sample
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [rmh_pkg::OUT_DATA_W-1:0]       m_tdata,  // [32:0] median_doubled,
                                                         // [43:33] sample_count, rest 0
  output logic                                 m_tuser   // [0] dropped
);
  import rmh_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BAL,
    ST_RES
  } state_t;

  state_t              state;
  logic                drop;
  row_cmd_t            lo_cmd;
  row_cmd_t            up_cmd;
  logic [SIZE_W-1:0]   lo_size;
  logic [SIZE_W-1:0]   up_size;
  logic [SAMPLE_W-1:0] lo_top;
  logic [SAMPLE_W-1:0] up_top;
  logic [TOTAL_W-1:0]  total;
  logic                full;
  logic                in_acc;
  logic                to_lower;
  logic                out_free;
  logic [MEDIAN_W-1:0] median;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign total    = TOTAL_W'(lo_size) + TOTAL_W'(up_size);
  assign full     = (total >= TOTAL_W'(CAPACITY));
  assign to_lower = (lo_size == '0) || ($signed(s_tdata) <= $signed(lo_top));
  assign out_free = !m_tvalid || m_tready;

  // commands to the two rows
  always_comb begin
    lo_cmd = '{op: CMD_HOLD, value: s_tdata};
    up_cmd = '{op: CMD_HOLD, value: s_tdata};
    unique case (state)
      ST_IDLE: begin
        if (in_acc && !full) begin
          if (to_lower) begin
            lo_cmd.op = CMD_PUSH;
          end else begin
            up_cmd.op = CMD_PUSH;
          end
        end
      end
      ST_BAL: begin
        if ({1'b0, lo_size} > ({1'b0, up_size} + TOTAL_W'(1))) begin
          lo_cmd.op    = CMD_POP;
          up_cmd.op    = CMD_PUSH;
          up_cmd.value = lo_top;
        end else if (up_size > lo_size) begin
          up_cmd.op    = CMD_POP;
          lo_cmd.op    = CMD_PUSH;
          lo_cmd.value = up_top;
        end
      end
      default: begin
        lo_cmd.op = CMD_HOLD;
      end
    endcase
  end

  rmh_row u_lower (
    .clk    (clk),
    .rst    (rst),
    .is_max (1'b1),
    .cmd    (lo_cmd),
    .size   (lo_size),
    .top    (lo_top)
  );

  rmh_row u_upper (
    .clk    (clk),
    .rst    (rst),
    .is_max (1'b0),
    .cmd    (up_cmd),
    .size   (up_size),
    .top    (up_top)
  );

  // twice the median from the two tops
  always_comb begin
    if (lo_size > up_size) begin
      median = {lo_top, 1'b0};
    end else if (lo_size != '0) begin
      median = MEDIAN_W'($signed(lo_top)) + MEDIAN_W'($signed(up_top));
    end else begin
      median = '0;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      drop     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // a taken word leaves unless a new one is loaded in the same cycle
      if (m_tready && !(state == ST_RES && out_free)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            drop  <= full;
            state <= full ? ST_RES : ST_BAL;
          end
        end
        ST_BAL: begin
          state <= ST_RES;
        end
        ST_RES: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_DATA_W'({COUNT_W'(total), median});
            m_tuser  <= drop;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // halves are balanced whenever the block waits for a sample
  a_balance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (lo_size >= up_size) &&
                           ({1'b0, lo_size} <= ({1'b0, up_size} + TOTAL_W'(1))))
    else $error("halves out of balance");

  // never more samples held than places
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    total <= TOTAL_W'(CAPACITY))
    else $error("sample count beyond capacity");

  // a dropped result is reported only when storage is full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RES && drop) |-> full)
    else $error("drop without full storage");

  // a result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("pending result overwritten");

  // s_tready drops once a sample is accepted
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_tready)
    else $error("sample accepted while busy");
`endif

endmodule

`default_nettype wire
